FILE: design/train_handle_lock_arbiter_unit_macros.svh
// Assertion macros used by the handle lock arbiter top level.
`ifndef TRAIN_HANDLE_LOCK_ARBITER_UNIT_MACROS_SVH
`define TRAIN_HANDLE_LOCK_ARBITER_UNIT_MACROS_SVH

// same-cycle implication
`define THLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define THLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/thla_pkg.sv
// Types, codes and microcode table of the handle lock arbiter.
package thla_pkg;

  typedef enum logic [2:0] {
    CMD_DRV_REV  = 3'd0,
    CMD_DRV_POW  = 3'd1,
    CMD_DRV_BRK  = 3'd2,
    CMD_LOCK_REV = 3'd3,
    CMD_LOCK_POW = 3'd4,
    CMD_LOCK_BRK = 3'd5,
    CMD_RESTART  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_INTERLOCK_EN = 2'd0,
    CFG_NRB          = 2'd1,
    CFG_REV_MODE     = 2'd2,
    CFG_INIT_BRAKE   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REV_FREE   = 2'd0,
    REV_REFUSE = 2'd1,
    REV_LOCK_N = 2'd2
  } rev_mode_e;

  typedef enum logic [1:0] {
    BRK_NONE   = 2'd0,
    BRK_MAXSVC = 2'd1,
    BRK_EMER   = 2'd2
  } brk_sel_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_EMIT = 2'd2
  } state_e;

  typedef enum logic [1:0] {
    H_REV = 2'd0,
    H_POW = 2'd1,
    H_BRK = 2'd2
  } hnd_e;

  typedef enum logic [2:0] {
    PS_IN   = 3'd0,
    PS_DRV  = 3'd1,
    PS_ZERO = 3'd2,
    PS_NRB  = 3'd3,
    PS_INIT = 3'd4
  } psrc_e;

  typedef enum logic [1:0] {
    AS_ZERO = 2'd0,
    AS_ONE  = 2'd1,
    AS_ACQ  = 2'd2,
    AS_POSZ = 2'd3
  } asrc_e;

  typedef enum logic [1:0] {
    ILC_NONE   = 2'd0,
    ILC_ALWAYS = 2'd1,
    ILC_POWER  = 2'd2
  } ilc_e;

  typedef enum logic [2:0] {
    CND_NEVER      = 3'd0,
    CND_ALWAYS     = 3'd1,
    CND_REV_REFUSE = 3'd2,
    CND_NRB_OFF    = 3'd3,
    CND_NO_LOCK_N  = 3'd4
  } cond_e;

  typedef logic [4:0] pc_t;

  typedef struct packed {
    logic  lock;
    hnd_e  hnd;
    psrc_e psrc;
    asrc_e asrc;
    logic  drv_wr;
    ilc_e  ilc;
    logic  cnt_clr;
    cond_e cond;
    logic  fin;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic       ie;
    logic [1:0] nrb;
    logic [1:0] rev_mode;
    logic [1:0] init_brk;
  } cfg_t;

  typedef struct packed {
    logic signed [1:0] rev;
    logic [3:0]        pow;
    logic [3:0]        brk;
    logic              il;
  } hout_t;

  localparam pc_t PC_DRV_REV  = 5'd0;
  localparam pc_t PC_NRB_JOIN = 5'd5;
  localparam pc_t PC_DRV_POW  = 5'd7;
  localparam pc_t PC_DRV_BRK  = 5'd11;
  localparam pc_t PC_LOCK_REV = 5'd14;
  localparam pc_t PC_LOCK_POW = 5'd15;
  localparam pc_t PC_LOCK_BRK = 5'd16;
  localparam pc_t PC_RESTART  = 5'd17;
  localparam pc_t PC_NOP      = 5'd23;
  localparam pc_t PC_LAST     = 5'd23;

  function automatic uword_t mk(input logic lock, input hnd_e hnd, input psrc_e psrc,
                                input asrc_e asrc, input logic drv_wr, input ilc_e ilc,
                                input logic cnt_clr, input cond_e cond, input logic fin,
                                input pc_t target);
    uword_t w;
    w.lock    = lock;
    w.hnd     = hnd;
    w.psrc    = psrc;
    w.asrc    = asrc;
    w.drv_wr  = drv_wr;
    w.ilc     = ilc;
    w.cnt_clr = cnt_clr;
    w.cond    = cond;
    w.fin     = fin;
    w.target  = target;
    return w;
  endfunction

  function automatic pc_t entry_pc(input logic [2:0] cmd);
    pc_t pc;
    case (cmd)
      CMD_DRV_REV:  pc = PC_DRV_REV;
      CMD_DRV_POW:  pc = PC_DRV_POW;
      CMD_DRV_BRK:  pc = PC_DRV_BRK;
      CMD_LOCK_REV: pc = PC_LOCK_REV;
      CMD_LOCK_POW: pc = PC_LOCK_POW;
      CMD_LOCK_BRK: pc = PC_LOCK_BRK;
      CMD_RESTART:  pc = PC_RESTART;
      default:      pc = PC_NOP;
    endcase
    return pc;
  endfunction

  // lock, hnd, pos src, add src, drv wr, il clear, cnt clear, cond, fin, target
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    case (pc)
      // driver reverser
      5'd0:  w = mk(1'b0, H_REV, PS_IN,   AS_ZERO, 1'b0, ILC_NONE,   1'b0,
                    CND_REV_REFUSE, 1'b1, '0);
      5'd1:  w = mk(1'b1, H_REV, PS_DRV,  AS_ZERO, 1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd2:  w = mk(1'b1, H_REV, PS_IN,   AS_ONE,  1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd3:  w = mk(1'b0, H_REV, PS_IN,   AS_ZERO, 1'b1, ILC_NONE,   1'b0,
                    CND_NRB_OFF, 1'b0, PC_NRB_JOIN);
      5'd4:  w = mk(1'b1, H_BRK, PS_NRB,  AS_POSZ, 1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd5:  w = mk(1'b0, H_REV, PS_IN,   AS_ZERO, 1'b0, ILC_NONE,   1'b0,
                    CND_NO_LOCK_N, 1'b1, '0);
      5'd6:  w = mk(1'b1, H_REV, PS_ZERO, AS_ONE,  1'b0, ILC_NONE,   1'b0,
                    CND_ALWAYS, 1'b1, '0);
      // driver power
      5'd7:  w = mk(1'b0, H_POW, PS_IN,   AS_ZERO, 1'b0, ILC_POWER,  1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd8:  w = mk(1'b1, H_POW, PS_DRV,  AS_ZERO, 1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd9:  w = mk(1'b1, H_POW, PS_IN,   AS_ONE,  1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd10: w = mk(1'b0, H_POW, PS_IN,   AS_ZERO, 1'b1, ILC_NONE,   1'b0,
                    CND_ALWAYS, 1'b1, '0);
      // driver brake
      5'd11: w = mk(1'b1, H_BRK, PS_DRV,  AS_ZERO, 1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd12: w = mk(1'b1, H_BRK, PS_IN,   AS_ONE,  1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd13: w = mk(1'b0, H_BRK, PS_IN,   AS_ZERO, 1'b1, ILC_NONE,   1'b0,
                    CND_ALWAYS, 1'b1, '0);
      // safety locks
      5'd14: w = mk(1'b1, H_REV, PS_IN,   AS_ACQ,  1'b0, ILC_NONE,   1'b0,
                    CND_ALWAYS, 1'b1, '0);
      5'd15: w = mk(1'b1, H_POW, PS_IN,   AS_ACQ,  1'b0, ILC_NONE,   1'b0,
                    CND_ALWAYS, 1'b1, '0);
      5'd16: w = mk(1'b1, H_BRK, PS_IN,   AS_ACQ,  1'b0, ILC_NONE,   1'b0,
                    CND_ALWAYS, 1'b1, '0);
      // restart
      5'd17: w = mk(1'b0, H_REV, PS_ZERO, AS_ZERO, 1'b1, ILC_ALWAYS, 1'b1,
                    CND_NEVER, 1'b0, '0);
      5'd18: w = mk(1'b0, H_POW, PS_ZERO, AS_ZERO, 1'b1, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd19: w = mk(1'b0, H_BRK, PS_INIT, AS_ZERO, 1'b1, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd20: w = mk(1'b1, H_REV, PS_ZERO, AS_ONE,  1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd21: w = mk(1'b1, H_POW, PS_ZERO, AS_ONE,  1'b0, ILC_NONE,   1'b0,
                    CND_NEVER, 1'b0, '0);
      5'd22: w = mk(1'b1, H_BRK, PS_DRV,  AS_ONE,  1'b0, ILC_NONE,   1'b0,
                    CND_ALWAYS, 1'b1, '0);
      default: w = mk(1'b0, H_REV, PS_IN, AS_ZERO, 1'b0, ILC_NONE,   1'b0,
                      CND_ALWAYS, 1'b1, '0);
    endcase
    return w;
  endfunction

endpackage

FILE: design/train_handle_lock_arbiter_unit.sv
// Top level of the train handle lock arbiter: microcode sequencer and ports.
//
//  channel   direction  handshake                 word
//  in        input      in_valid_i / in_ready_o   command, position, acquire, moving
//  out       output     out_valid_o / out_ready_i eff_reverser/power/brake, interlock
//  cfg       input      cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// A word is accepted, then runs its microcode program of 1 to 7 steps (driver
// reverser longest, each step one count update and reselect), then is
// emitted. One word in flight at a time.
// Reset clears counts, driver positions, handles and interlock at once.
// A stalled result holds the sequencer in its emit state; the next word is
// accepted once the result has moved into the output register and the sequencer is idle.
module train_handle_lock_arbiter_unit #(
  parameter int TOP_POWER  = 8,
  parameter int TOP_BRAKE  = 9,
  parameter int COUNT_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_addr_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic signed [4:0] position_i,
  input  logic              acquire_i,
  input  logic              moving_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [1:0] eff_reverser_o,
  output logic [3:0]        eff_power_o,
  output logic [3:0]        eff_brake_o,
  output logic              interlock_active_o
);
  import thla_pkg::*;

  `include "train_handle_lock_arbiter_unit_macros.svh"

  state_e            state_q, state_d;
  pc_t               pc_q, pc_d;
  cfg_t              cfg_q;
  logic signed [4:0] pos_q;
  logic              acq_q;
  logic              moving_q;
  uword_t            uw;
  logic              cond_hit;
  logic              exec;
  logic              slot_free;
  logic              emit_load;
  hout_t             hout;
  hout_t             out_q;
  logic              out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ie       <= 1'b0;
      cfg_q.nrb      <= BRK_NONE;
      cfg_q.rev_mode <= REV_FREE;
      cfg_q.init_brk <= BRK_EMER;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_INTERLOCK_EN: cfg_q.ie       <= cfg_wdata_i[0];
        CFG_NRB:          cfg_q.nrb      <= cfg_wdata_i;
        CFG_REV_MODE:     cfg_q.rev_mode <= cfg_wdata_i;
        CFG_INIT_BRAKE:   cfg_q.init_brk <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign uw        = ucode_rom(pc_q);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (uw.cond)
      CND_NEVER:      cond_hit = 1'b0;
      CND_ALWAYS:     cond_hit = 1'b1;
      CND_REV_REFUSE: cond_hit = (cfg_q.rev_mode == REV_REFUSE) && moving_q &&
                                 (pos_q != 5'sd0);
      CND_NRB_OFF:    cond_hit = (cfg_q.nrb == BRK_NONE);
      CND_NO_LOCK_N:  cond_hit = !((cfg_q.rev_mode == REV_LOCK_N) && moving_q);
      default:        cond_hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_RUN;
      S_RUN:   if (cond_hit && uw.fin) state_d = S_EMIT;
      S_EMIT:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready_o = 1'b0;
    exec       = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_RUN:   exec       = 1'b1;
      S_EMIT:  emit_load  = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (in_valid_i && in_ready_o) begin
      pc_d = entry_pc(command_i);
    end else if (exec && !(cond_hit && uw.fin)) begin
      pc_d = cond_hit ? uw.target : pc_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (emit_load)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pos_q    <= position_i;
      acq_q    <= acquire_i;
      moving_q <= moving_i;
    end
    if (emit_load) out_q <= hout;
  end

  thla_datapath #(
    .TOP_POWER (TOP_POWER),
    .TOP_BRAKE (TOP_BRAKE),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .exec_i(exec),
    .uw_i  (uw),
    .cfg_i (cfg_q),
    .pos_i (pos_q),
    .acq_i (acq_q),
    .hout_o(hout)
  );

  assign out_valid_o        = out_valid_q;
  assign eff_reverser_o     = out_q.rev;
  assign eff_power_o        = out_q.pow;
  assign eff_brake_o        = out_q.brk;
  assign interlock_active_o = out_q.il;

  `THLA_ASSERT_NEXT(a_accept_runs, in_valid_i && in_ready_o, state_q == S_RUN, "accept did not start program")
  `THLA_ASSERT_NOW(a_pc_range, state_q == S_RUN, pc_q <= PC_LAST, "microcode pc out of range")
  `THLA_ASSERT_NOW(a_pow_range, out_valid_o, eff_power_o <= 4'(TOP_POWER), "power notch beyond top")
  `THLA_ASSERT_NOW(a_brk_range, out_valid_o, eff_brake_o <= 4'(TOP_BRAKE), "brake step beyond top")
  `THLA_ASSERT_NEXT(a_emit_only, emit_load, out_valid_o && state_q == S_IDLE, "result load lost")

endmodule

FILE: design/thla_datapath.sv
// Request counts, driver positions and handle selection of the arbiter.
module thla_datapath #(
  parameter int TOP_POWER  = 8,
  parameter int TOP_BRAKE  = 9,
  parameter int COUNT_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  thla_pkg::uword_t    uw_i,
  input  thla_pkg::cfg_t      cfg_i,
  input  logic signed [4:0]   pos_i,
  input  logic                acq_i,
  output thla_pkg::hout_t     hout_o
);
  import thla_pkg::*;

  localparam int PN  = TOP_POWER + 1;
  localparam int BN  = TOP_BRAKE + 1;
  localparam int PIW = (PN > 1) ? $clog2(PN) : 1;
  localparam int BIW = (BN > 1) ? $clog2(BN) : 1;
  localparam logic [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic [COUNT_BITS-1:0] rev_cnt_q [3];
  logic [COUNT_BITS-1:0] rev_cnt_d [3];
  logic [COUNT_BITS-1:0] pow_cnt_q [PN];
  logic [COUNT_BITS-1:0] pow_cnt_d [PN];
  logic [COUNT_BITS-1:0] brk_cnt_q [BN];
  logic [COUNT_BITS-1:0] brk_cnt_d [BN];

  logic signed [4:0] drv_rev_q, drv_rev_d;
  logic signed [4:0] drv_pow_q, drv_pow_d;
  logic signed [4:0] drv_brk_q, drv_brk_d;
  hout_t             h_q, h_d;

  logic signed [4:0] pos_sel;
  logic signed [4:0] nrb_pos;
  logic signed [4:0] init_pos;
  logic              add_sel;
  logic              rev_ok, pow_ok, brk_ok;
  logic [1:0]        rev_idx;
  logic [PIW-1:0]    pow_idx;
  logic [BIW-1:0]    brk_idx;
  logic              pow_any, brk_any;
  logic [3:0]        pow_pick, brk_pick;
  logic              do_lock;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c,
                                                 input logic add);
    logic [COUNT_BITS-1:0] r;
    r = c;
    if (add) begin
      if (c != CMAX) r = c + 1'b1;
    end else begin
      if (c != CMIN) r = c - 1'b1;
    end
    return r;
  endfunction

  function automatic logic held(input logic [COUNT_BITS-1:0] c);
    return !c[COUNT_BITS-1] && (c != '0);
  endfunction

  assign nrb_pos  = (cfg_i.nrb == BRK_MAXSVC) ? 5'(TOP_BRAKE - 1) : 5'(TOP_BRAKE);
  assign init_pos = (cfg_i.init_brk == BRK_EMER)   ? 5'(TOP_BRAKE) :
                    (cfg_i.init_brk == BRK_MAXSVC) ? 5'(TOP_BRAKE - 1) : 5'sd0;

  always_comb begin
    case (uw_i.psrc)
      PS_IN:   pos_sel = pos_i;
      PS_DRV: begin
        case (uw_i.hnd)
          H_REV:   pos_sel = drv_rev_q;
          H_POW:   pos_sel = drv_pow_q;
          H_BRK:   pos_sel = drv_brk_q;
          default: pos_sel = drv_rev_q;
        endcase
      end
      PS_ZERO: pos_sel = 5'sd0;
      PS_NRB:  pos_sel = nrb_pos;
      PS_INIT: pos_sel = init_pos;
      default: pos_sel = 5'sd0;
    endcase
  end

  always_comb begin
    case (uw_i.asrc)
      AS_ZERO: add_sel = 1'b0;
      AS_ONE:  add_sel = 1'b1;
      AS_ACQ:  add_sel = acq_i;
      AS_POSZ: add_sel = (pos_i == 5'sd0);
      default: add_sel = 1'b0;
    endcase
  end

  assign rev_ok  = (pos_sel >= -5'sd1) && (pos_sel <= 5'sd1);
  assign pow_ok  = (pos_sel >= 5'sd0) && (pos_sel <= $signed(5'(TOP_POWER)));
  assign brk_ok  = (pos_sel >= 5'sd0) && (pos_sel <= $signed(5'(TOP_BRAKE)));
  assign rev_idx = pos_sel[1:0] + 2'd1;
  assign pow_idx = pos_sel[PIW-1:0];
  assign brk_idx = pos_sel[BIW-1:0];
  assign do_lock = exec_i && uw_i.lock;

  // count update
  always_comb begin
    rev_cnt_d = rev_cnt_q;
    pow_cnt_d = pow_cnt_q;
    brk_cnt_d = brk_cnt_q;
    if (exec_i && uw_i.cnt_clr) begin
      for (int i = 0; i < 3; i++) rev_cnt_d[i] = '0;
      for (int i = 0; i < PN; i++) pow_cnt_d[i] = '0;
      for (int i = 0; i < BN; i++) brk_cnt_d[i] = '0;
    end else if (do_lock) begin
      case (uw_i.hnd)
        H_REV: if (rev_ok) rev_cnt_d[rev_idx] = bump(rev_cnt_q[rev_idx], add_sel);
        H_POW: if (pow_ok) pow_cnt_d[pow_idx] = bump(pow_cnt_q[pow_idx], add_sel);
        H_BRK: if (brk_ok) brk_cnt_d[brk_idx] = bump(brk_cnt_q[brk_idx], add_sel);
        default: ;
      endcase
    end
  end

  // lowest held notch, highest held step
  always_comb begin
    pow_any  = 1'b0;
    pow_pick = '0;
    for (int i = PN - 1; i >= 0; i--) begin
      if (held(pow_cnt_d[i])) begin
        pow_any  = 1'b1;
        pow_pick = 4'(i);
      end
    end
    brk_any  = 1'b0;
    brk_pick = '0;
    for (int i = 0; i < BN; i++) begin
      if (held(brk_cnt_d[i])) begin
        brk_any  = 1'b1;
        brk_pick = 4'(i);
      end
    end
  end

  always_comb begin
    h_d       = h_q;
    drv_rev_d = drv_rev_q;
    drv_pow_d = drv_pow_q;
    drv_brk_d = drv_brk_q;
    if (exec_i) begin
      case (uw_i.ilc)
        ILC_ALWAYS: h_d.il = 1'b0;
        ILC_POWER:  if (pos_i == 5'sd0 || drv_pow_q == 5'sd0) h_d.il = 1'b0;
        default: ;
      endcase
      if (uw_i.drv_wr) begin
        case (uw_i.hnd)
          H_REV:   drv_rev_d = pos_sel;
          H_POW:   drv_pow_d = pos_sel;
          H_BRK:   drv_brk_d = pos_sel;
          default: ;
        endcase
      end
    end
    if (do_lock) begin
      case (uw_i.hnd)
        H_REV: begin
          if (rev_ok) begin
            if (held(rev_cnt_d[1]))      h_d.rev = 2'sd0;
            else if (held(rev_cnt_d[2])) h_d.rev = 2'sd1;
            else if (held(rev_cnt_d[0])) h_d.rev = -2'sd1;
          end
        end
        H_POW: begin
          if (pow_ok) begin
            if (h_q.il && cfg_i.ie) h_d.pow = '0;
            else if (pow_any)       h_d.pow = pow_pick;
          end
        end
        H_BRK: begin
          if (brk_ok && brk_any) begin
            h_d.brk = brk_pick;
            if (brk_pick != '0) begin
              h_d.il = 1'b1;
              if (cfg_i.ie) h_d.pow = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) rev_cnt_q[i] <= '0;
      for (int i = 0; i < PN; i++) pow_cnt_q[i] <= '0;
      for (int i = 0; i < BN; i++) brk_cnt_q[i] <= '0;
      drv_rev_q <= '0;
      drv_pow_q <= '0;
      drv_brk_q <= '0;
      h_q       <= '0;
    end else begin
      rev_cnt_q <= rev_cnt_d;
      pow_cnt_q <= pow_cnt_d;
      brk_cnt_q <= brk_cnt_d;
      drv_rev_q <= drv_rev_d;
      drv_pow_q <= drv_pow_d;
      drv_brk_q <= drv_brk_d;
      h_q       <= h_d;
    end
  end

  assign hout_o = h_q;

endmodule

FILE: tb/testbench.sv
// Testbench for the train handle lock arbiter: predicts every result word and checks it.
`timescale 1ns / 1ps

module testbench;
  import thla_pkg::*;

  localparam int TOP_POWER  = 8;
  localparam int TOP_BRAKE  = 9;
  localparam int COUNT_BITS = 8;
  localparam int CNT_MAX    = (1 << (COUNT_BITS - 1)) - 1;
  localparam int CNT_MIN    = -(1 << (COUNT_BITS - 1));

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic [1:0] SEL_SPARE  = 2'd3;

  localparam int PHASE_WORDS    = 255;
  localparam int SAT_RUN        = 132;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  class handle_tracker;
    bit         ie;
    logic [1:0] nrb;
    logic [1:0] rev_mode;
    logic [1:0] init_brk;
    int         rev_cnt[3];
    int         pow_cnt[TOP_POWER + 1];
    int         brk_cnt[TOP_BRAKE + 1];
    int         drv_rev, drv_pow, drv_brk;
    int         hnd_rev, hnd_pow, hnd_brk;
    bit         il;
    hout_t      expected_handles[$];
    int         mismatches;
    int         results_matched;

    function new();
      ie              = 1'b0;
      nrb             = BRK_NONE;
      rev_mode        = REV_FREE;
      init_brk        = BRK_EMER;
      clear_counts();
      drv_rev         = 0;
      drv_pow         = 0;
      drv_brk         = 0;
      hnd_rev         = 0;
      hnd_pow         = 0;
      hnd_brk         = 0;
      il              = 1'b0;
      mismatches      = 0;
      results_matched = 0;
    endfunction

    function void clear_counts();
      foreach (rev_cnt[i]) rev_cnt[i] = 0;
      foreach (pow_cnt[i]) pow_cnt[i] = 0;
      foreach (brk_cnt[i]) brk_cnt[i] = 0;
    endfunction

    function int bumped(int c, bit add);
      if (add) return (c < CNT_MAX) ? c + 1 : c;
      return (c > CNT_MIN) ? c - 1 : c;
    endfunction

    function void lock_rev(int p, bit add);
      if (p < -1 || p > 1) return;
      rev_cnt[p + 1] = bumped(rev_cnt[p + 1], add);
      // neutral wins, then forward, then reverse
      if (rev_cnt[1] > 0) hnd_rev = 0;
      else if (rev_cnt[2] > 0) hnd_rev = 1;
      else if (rev_cnt[0] > 0) hnd_rev = -1;
    endfunction

    function void lock_pow(int p, bit add);
      bit found;
      found = 1'b0;
      if (p < 0 || p > TOP_POWER) return;
      pow_cnt[p] = bumped(pow_cnt[p], add);
      if (il && ie) begin
        hnd_pow = 0;
        return;
      end
      for (int i = 0; i <= TOP_POWER; i++) begin
        if (!found && pow_cnt[i] > 0) begin
          hnd_pow = i;
          found   = 1'b1;
        end
      end
    endfunction

    function void lock_brk(int p, bit add);
      bit found;
      found = 1'b0;
      if (p < 0 || p > TOP_BRAKE) return;
      brk_cnt[p] = bumped(brk_cnt[p], add);
      for (int i = TOP_BRAKE; i >= 0; i--) begin
        if (!found && brk_cnt[i] > 0) begin
          found   = 1'b1;
          hnd_brk = i;
          if (i > 0) begin
            il = 1'b1;
            if (ie) hnd_pow = 0;
          end
        end
      end
    endfunction

    function void restart();
      drv_rev = 0;
      drv_pow = 0;
      il      = 1'b0;
      if (init_brk == BRK_EMER) drv_brk = TOP_BRAKE;
      else if (init_brk == BRK_MAXSVC) drv_brk = TOP_BRAKE - 1;
      else drv_brk = 0;
      clear_counts();
      lock_rev(0, 1'b1);
      lock_pow(0, 1'b1);
      lock_brk(drv_brk, 1'b1);
    endfunction

    function void set_register(cfg_reg_e idx, logic [1:0] v);
      case (idx)
        CFG_INTERLOCK_EN: ie       = v[0];
        CFG_NRB:          nrb      = v;
        CFG_REV_MODE:     rev_mode = v;
        CFG_INIT_BRAKE:   init_brk = v;
        default: ;
      endcase
    endfunction

    function void take_command(logic [2:0] cmd, logic signed [4:0] pos, bit acq, bit mov);
      int    p;
      hout_t want;
      p = pos;
      case (cmd)
        CMD_DRV_REV: begin
          if (!(rev_mode == REV_REFUSE && mov && p != 0)) begin
            lock_rev(drv_rev, 1'b0);
            lock_rev(p, 1'b1);
            drv_rev = p;
            if (nrb != BRK_NONE)
              lock_brk((nrb == BRK_MAXSVC) ? TOP_BRAKE - 1 : TOP_BRAKE, p == 0);
            if (rev_mode == REV_LOCK_N && mov) lock_rev(0, 1'b1);
          end
        end
        CMD_DRV_POW: begin
          if (p == 0 || drv_pow == 0) il = 1'b0;
          lock_pow(drv_pow, 1'b0);
          lock_pow(p, 1'b1);
          drv_pow = p;
        end
        CMD_DRV_BRK: begin
          lock_brk(drv_brk, 1'b0);
          lock_brk(p, 1'b1);
          drv_brk = p;
        end
        CMD_LOCK_REV: lock_rev(p, acq);
        CMD_LOCK_POW: lock_pow(p, acq);
        CMD_LOCK_BRK: lock_brk(p, acq);
        CMD_RESTART:  restart();
        default: ;
      endcase
      want.rev = hnd_rev[1:0];
      want.pow = hnd_pow[3:0];
      want.brk = hnd_brk[3:0];
      want.il  = il;
      expected_handles.push_back(want);
    endfunction

    function void field_check(string name, int w, int g);
      if (w != g) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, w, g);
      end
    endfunction

    function void match_result(hout_t got);
      hout_t want;
      if (expected_handles.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, got rev %0d pow %0d brk %0d il %0d",
                 $time, got.rev, got.pow, got.brk, got.il);
        return;
      end
      want = expected_handles.pop_front();
      results_matched++;
      field_check("eff_reverser", want.rev, got.rev);
      field_check("eff_power", want.pow, got.pow);
      field_check("eff_brake", want.brk, got.brk);
      field_check("interlock_active", want.il, got.il);
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_addr_i  = CFG_INTERLOCK_EN;
  logic [1:0]        cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [2:0]        command_i   = CMD_DRV_REV;
  logic signed [4:0] position_i  = '0;
  logic              acquire_i   = 1'b0;
  logic              moving_i    = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [1:0] eff_reverser_o;
  logic [3:0]        eff_power_o;
  logic [3:0]        eff_brake_o;
  logic              interlock_active_o;

  handle_tracker tracker = new();
  int words_sent   = 0;
  int sat_runs     = 0;
  int settings_made = 0;
  int idle_cycles  = 0;

  train_handle_lock_arbiter_unit #(
    .TOP_POWER (TOP_POWER),
    .TOP_BRAKE (TOP_BRAKE),
    .COUNT_BITS(COUNT_BITS)
  ) uut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin : port_monitor
    hout_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.rev = eff_reverser_o;
      seen.pow = eff_power_o;
      seen.brk = eff_brake_o;
      seen.il  = interlock_active_o;
      tracker.match_result(seen);
    end
    if (rst_ni && in_valid_i && in_ready_o)
      tracker.take_command(command_i, position_i, acquire_i, moving_i);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no handshake in %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result sink: random stalls, quiet stretches, two long hold-offs
  initial begin : result_sink
    int taken;
    int gap;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == 300 || taken == 1000) gap = HOLD_CYCLES;
      else if (((taken / 128) % 4) == 2) gap = 0;
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  task automatic send_word(logic [2:0] cmd, int pos, bit acq, bit mov);
    int gap;
    gap = (((words_sent / 100) % 5) == 3) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i  <= cmd;
    position_i <= pos[4:0];
    acquire_i  <= acq;
    moving_i   <= mov;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic int handle_pos(logic [2:0] cmd, bit in_range);
    int p;
    p = int'($urandom_range(0, 31)) - 16;
    if (in_range) begin
      case (cmd)
        CMD_DRV_REV, CMD_LOCK_REV: p = int'($urandom_range(0, 2)) - 1;
        CMD_DRV_POW, CMD_LOCK_POW: p = $urandom_range(0, TOP_POWER);
        CMD_DRV_BRK, CMD_LOCK_BRK: p = $urandom_range(0, TOP_BRAKE);
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic saturate_run();
    logic [2:0] cmd;
    int         pos;
    bit         acq;
    cmd = 3'(CMD_LOCK_REV + $urandom_range(0, 2));
    pos = handle_pos(cmd, 1'b1);
    acq = $urandom_range(0, 1);
    repeat (SAT_RUN) send_word(cmd, pos, acq, $urandom_range(0, 1));
    sat_runs++;
  endtask

  task automatic random_phase(int n_words, bit with_sat);
    int         stop_at;
    int         kind;
    int         len;
    int         pos;
    logic [2:0] cmd;
    logic [2:0] held;
    stop_at = words_sent + n_words;
    if (with_sat) saturate_run();
    while (words_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(2, 8);
      case (kind)
        0, 1, 2, 3: repeat (len) begin
          cmd = 3'(CMD_DRV_REV + $urandom_range(0, 2));
          send_word(cmd, handle_pos(cmd, $urandom_range(0, 6) != 0),
                    $urandom_range(0, 1), $urandom_range(0, 1));
        end
        4, 5: repeat (len) begin
          cmd = 3'(CMD_LOCK_REV + $urandom_range(0, 2));
          send_word(cmd, handle_pos(cmd, $urandom_range(0, 6) != 0),
                    $urandom_range(0, 1), $urandom_range(0, 1));
        end
        6: send_word(CMD_RESTART, handle_pos(CMD_RESTART, 1'b0),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        7: repeat (len)
          send_word(3'($urandom), handle_pos(CMD_UNUSED, 1'b0),
                    $urandom_range(0, 1), $urandom_range(0, 1));
        8: repeat (len)
          send_word(CMD_DRV_REV, handle_pos(CMD_DRV_REV, 1'b1),
                    $urandom_range(0, 1), 1'b1);
        default: begin
          // safety lock held across some driver moves, then released
          held = 3'(CMD_LOCK_REV + $urandom_range(0, 2));
          pos  = handle_pos(held, 1'b1);
          send_word(held, pos, 1'b1, $urandom_range(0, 1));
          repeat (len) begin
            cmd = 3'(CMD_DRV_REV + $urandom_range(0, 2));
            send_word(cmd, handle_pos(cmd, 1'b1), $urandom_range(0, 1),
                      $urandom_range(0, 1));
          end
          send_word(held, pos, 1'b0, $urandom_range(0, 1));
        end
      endcase
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (tracker.expected_handles.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_config(bit ie, logic [1:0] nrb, logic [1:0] rm, logic [1:0] ib);
    cfg_reg_e   idx[4];
    logic [1:0] val[4];
    idx = '{CFG_INTERLOCK_EN, CFG_NRB, CFG_REV_MODE, CFG_INIT_BRAKE};
    val = '{{1'b0, ie}, nrb, rm, ib};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx[k];
      cfg_wdata_i <= val[k];
      tracker.set_register(idx[k], val[k]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_made++;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(CMD_UNUSED, 0, 1'b0, 1'b0);
    send_word(CMD_RESTART, 0, 1'b0, 1'b0);
    send_word(CMD_DRV_REV, 1, 1'b0, 1'b0);
    send_word(CMD_DRV_REV, -1, 1'b1, 1'b1);
    send_word(CMD_DRV_REV, 2, 1'b0, 1'b0);
    send_word(CMD_DRV_REV, 0, 1'b0, 1'b1);
    send_word(CMD_DRV_POW, TOP_POWER, 1'b0, 1'b0);
    send_word(CMD_DRV_POW, 15, 1'b1, 1'b0);
    send_word(CMD_DRV_POW, -16, 1'b0, 1'b1);
    send_word(CMD_DRV_POW, 0, 1'b0, 1'b0);
    send_word(CMD_DRV_BRK, 0, 1'b0, 1'b0);
    send_word(CMD_DRV_BRK, TOP_BRAKE, 1'b0, 1'b0);
    send_word(CMD_DRV_BRK, TOP_BRAKE + 1, 1'b0, 1'b0);
    send_word(CMD_DRV_BRK, -1, 1'b1, 1'b1);
    send_word(CMD_LOCK_REV, -1, 1'b1, 1'b0);
    send_word(CMD_LOCK_REV, -1, 1'b0, 1'b0);
    send_word(CMD_LOCK_REV, -1, 1'b0, 1'b1);
    send_word(CMD_LOCK_POW, 0, 1'b1, 1'b0);
    send_word(CMD_LOCK_POW, TOP_POWER, 1'b0, 1'b0);
    send_word(CMD_LOCK_POW, TOP_POWER + 1, 1'b1, 1'b0);
    send_word(CMD_LOCK_BRK, TOP_BRAKE, 1'b1, 1'b0);
    send_word(CMD_LOCK_BRK, TOP_BRAKE, 1'b0, 1'b1);
    send_word(CMD_LOCK_BRK, 0, 1'b1, 1'b0);
    send_word(CMD_UNUSED, 15, 1'b1, 1'b1);

    random_phase(PHASE_WORDS, 1'b0);
    quiesce();
    set_config(1'b1, BRK_MAXSVC, REV_REFUSE, BRK_MAXSVC);
    random_phase(PHASE_WORDS, 1'b1);
    quiesce();
    set_config(1'b0, BRK_EMER, REV_LOCK_N, BRK_NONE);
    random_phase(PHASE_WORDS, 1'b0);
    quiesce();
    set_config(1'b1, SEL_SPARE, SEL_SPARE, SEL_SPARE);
    random_phase(PHASE_WORDS, 1'b1);
    quiesce();
    set_config(1'b1, BRK_NONE, REV_FREE, BRK_EMER);
    random_phase(PHASE_WORDS, 1'b0);
    quiesce();
    set_config($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 3),
               $urandom_range(0, 3));
    random_phase(PHASE_WORDS, 1'b1);
    quiesce();
    repeat (20) @(negedge clk_i);

    $display("Covered %0d command words and %0d compared result words over %0d settings,",
             words_sent, tracker.results_matched, settings_made);
    $display("including %0d saturating lock runs, restarts, bad positions and output stalls.",
             sat_runs);
    if (tracker.mismatches == 0 && tracker.expected_handles.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
